// File: src/hrle_pkg.sv
package hrle_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  localparam logic [15:0] FRAME_PIXELS_RST = 16'd2000;
  localparam logic [15:0] FRAME_INDEX_RST  = 16'd1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_F     = 8'h46;

  // number of run descriptors one character pushes
  localparam logic [1:0] PUSH_NONE = 2'd0;
  localparam logic [1:0] PUSH_ONE  = 2'd1;
  localparam logic [1:0] PUSH_TWO  = 2'd2;

  typedef struct packed {
    logic [6:0]  run_count;
    logic        lit;
    logic [15:0] frame_index;
    logic        end_of_frame;
    logic        last;
  } run_t;

  typedef struct packed {
    logic [1:0] n;
    run_t       first;
    run_t       second;
  } push_t;

  function automatic logic [3:0] nibble_of(input logic [7:0] ch);
    logic [7:0] d;
    d = 8'h00;
    if (ch >= CH_0 && ch <= CH_9) begin
      d = ch - CH_0;
    end else if (ch >= CH_A && ch <= CH_F) begin
      d = ch - CH_A + 8'd10;
    end
    return d[3:0];
  endfunction

endpackage

// File: src/hrle_out_fifo.sv
module hrle_out_fifo
  import hrle_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  push_t             push,
  input  logic              pop,
  output run_t              head,
  output logic [QCNT_W-1:0] count
);

  run_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_nxt  = wr_r + QPTR_W'(push.n);
    rd_nxt  = rd_r + QPTR_W'(pop);
    cnt_nxt = cnt_r + QCNT_W'(push.n) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != PUSH_NONE) begin
      mem[wr_r] <= push.first;
    end
    if (push.n == PUSH_TWO) begin
      mem[wr_r + QPTR_W'(1)] <= push.second;
    end
  end

  assign head  = mem[rd_r];
  assign count = cnt_r;

endmodule

// File: src/hex_rle_frame_decoder_core.sv
// Output: a run descriptor enters the result queue when the character that completes
//   its byte is accepted; a split run queues its remainder behind the closing part.
// Throughput: one character per cycle while in_stall is low; a four-entry result
//   queue decouples the sides, and a split run takes two of its entries.
// Reset (rst_n low, synchronous): queue empty, no nibble held, position 0,
//   frame index 1, frame size 2000.
module hex_rle_frame_decoder_core
  import hrle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // character input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  // run descriptor output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_run_count,
  output logic        out_lit,
  output logic [15:0] out_frame_index,
  output logic        out_end_of_frame,
  output logic        out_last,
  // frame size register
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data
);

  // decoder state
  logic        pend_r, pend_nxt;
  logic [3:0]  hi_r, hi_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] frm_r, frm_nxt;
  logic [15:0] fpix_r;

  logic              in_acc;
  logic              is_ws;
  logic [3:0]        nib;
  logic [7:0]        byte_v;
  logic [6:0]        len;
  logic [15:0]       pos_c;
  logic [16:0]       sum;
  logic              crossing;
  logic [15:0]       closing16;
  logic [6:0]        closing;
  logic [6:0]        rest;
  logic [15:0]       frm_inc;
  push_t             push;
  run_t              head;
  logic [QCNT_W-1:0] q_count;
  logic              out_acc;

  // Stall while the queue might not hold a split run (two entries).
  assign in_stall = q_count > QCNT_W'(QDEPTH - 2);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  assign is_ws  = (in_char_code == CH_SPACE) || (in_char_code == CH_CR) ||
                  (in_char_code == CH_LF);
  assign nib    = nibble_of(in_char_code);
  assign byte_v = {hi_r, nib};
  assign len    = byte_v[6:0];

  // A position left beyond a lowered frame size counts as the frame end.
  assign pos_c     = (pos_r > fpix_r) ? fpix_r : pos_r;
  assign sum       = {1'b0, pos_c} + 17'(len);
  assign crossing  = sum > {1'b0, fpix_r};
  // only used when crossing, where it is below len and fits 7 bits
  assign closing16 = fpix_r - pos_c;
  assign closing   = closing16[6:0];
  assign rest      = len - closing;
  assign frm_inc   = frm_r + 16'd1;

  always_comb begin
    pend_nxt = pend_r;
    hi_nxt   = hi_r;
    pos_nxt  = pos_r;
    frm_nxt  = frm_r;

    push.n                   = PUSH_NONE;
    push.first.run_count     = len;
    push.first.lit           = byte_v[7];
    push.first.frame_index   = frm_r;
    push.first.end_of_frame  = 1'b0;
    push.first.last          = 1'b1;
    push.second.run_count    = rest;
    push.second.lit          = byte_v[7];
    push.second.frame_index  = frm_inc;
    push.second.end_of_frame = 1'b0;
    push.second.last         = 1'b1;

    if (in_acc && !is_ws) begin
      if (!pend_r) begin
        // first nibble of a byte: hold it
        pend_nxt = 1'b1;
        hi_nxt   = nib;
      end else begin
        pend_nxt = 1'b0;
        if (crossing) begin
          // closing part ends this frame, remainder opens the next
          push.n                  = PUSH_TWO;
          push.first.run_count    = closing;
          push.first.end_of_frame = 1'b1;
          push.first.last         = 1'b0;
          frm_nxt                 = frm_inc;
          pos_nxt                 = 16'(rest);
        end else begin
          push.n  = PUSH_ONE;
          pos_nxt = sum[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      hi_r   <= '0;
      pos_r  <= '0;
      frm_r  <= FRAME_INDEX_RST;
      fpix_r <= FRAME_PIXELS_RST;
    end else begin
      pend_r <= pend_nxt;
      hi_r   <= hi_nxt;
      pos_r  <= pos_nxt;
      frm_r  <= frm_nxt;
      if (cfg_write_en) begin
        fpix_r <= cfg_write_data;
      end
    end
  end

  hrle_out_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (out_acc),
    .head  (head),
    .count (q_count)
  );

  assign out_valid        = q_count != '0;
  assign out_run_count    = head.run_count;
  assign out_lit          = head.lit;
  assign out_frame_index  = head.frame_index;
  assign out_end_of_frame = head.end_of_frame;
  assign out_last         = head.last;

endmodule

// File: tb/sv/tb_hex_rle_frame_decoder_core.sv
module tb_hex_rle_frame_decoder_core
  import hrle_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Generous ceiling: about 1.7k characters with sender gaps (idle up to 71%),
  // up to two runs each behind a receiver that stalls 71% of the time.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Margin after the completing character for runs still in the result queue.
  localparam int unsigned SETTLE_CYCLES = 6;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_char_code;
  logic        out_valid;
  logic        out_stall;
  logic [6:0]  out_run_count;
  logic        out_lit;
  logic [15:0] out_frame_index;
  logic        out_end_of_frame;
  logic        out_last;
  logic        cfg_write_en;
  logic [15:0] cfg_write_data;

  hex_rle_frame_decoder_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_run_count    (out_run_count),
    .out_lit          (out_lit),
    .out_frame_index  (out_frame_index),
    .out_end_of_frame (out_end_of_frame),
    .out_last         (out_last),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Characters waiting to be offered, and run descriptors still owed by the DUT.
  logic [7:0]  pending_chars[$];
  run_t        runs_due[$];

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned cycle_count     = 0;
  int unsigned errors          = 0;
  logic        in_taken        = 1'b0;
  run_t        want;

  // Decoder state as the DUT should hold it
  logic [15:0] frame_size   = FRAME_PIXELS_RST;
  logic        half_held    = 1'b0;
  logic [3:0]  held_nibble  = 4'd0;
  logic [15:0] position     = 16'd0;
  logic [15:0] frame_no     = FRAME_INDEX_RST;

  // Directed text, default frame size: whitespace between the two digits of a
  // byte, lowercase and non-hex characters counting as zero, blank length 0.
  logic [7:0] opening_text [13] = '{
    CH_F, CH_SPACE, CH_F, CH_CR, "7", CH_LF, CH_F, "a", CH_0, CH_9, CH_A, 8'hFF, "8"
  };
  // Directed text, frame size 128 with the position (288) already past it:
  // zero-pixel close, exact fill left open, zero-length run on a full frame,
  // zero-pixel close again, then an ordinary split.
  logic [7:0] frame_edge_text [12] = '{
    "8", "5", "7", "B", "8", "0", "0", "1", "C", "E", "D", "2"
  };

  // Expected runs for one accepted character
  task automatic decode_char(input logic [7:0] ch);
    logic [3:0]  nib;
    logic [7:0]  code_byte;
    logic [6:0]  len;
    logic [16:0] start;
    logic [15:0] closing;
    run_t        r;
    if (ch == CH_SPACE || ch == CH_CR || ch == CH_LF) return;
    nib = 4'd0;
    if (ch >= CH_0 && ch <= CH_9) nib = 4'(ch - CH_0);
    else if (ch >= CH_A && ch <= CH_F) nib = 4'(ch - CH_A) + 4'd10;
    if (!half_held) begin
      held_nibble = nib;
      half_held   = 1'b1;
      return;
    end
    half_held = 1'b0;
    code_byte = {held_nibble, nib};
    len       = code_byte[6:0];
    // a shrunken frame clamps the position to its end
    start     = (position > frame_size) ? {1'b0, frame_size} : {1'b0, position};
    r.lit     = code_byte[7];
    if (start + len > {1'b0, frame_size}) begin
      closing        = frame_size - start[15:0];
      r.run_count    = closing[6:0];
      r.frame_index  = frame_no;
      r.end_of_frame = 1'b1;
      r.last         = 1'b0;
      runs_due.push_back(r);
      frame_no       = frame_no + 16'd1;
      // remainder opens the next frame, split only once
      r.run_count    = len - closing[6:0];
      r.frame_index  = frame_no;
      r.end_of_frame = 1'b0;
      r.last         = 1'b1;
      runs_due.push_back(r);
      position       = {9'd0, r.run_count};
    end else begin
      r.run_count    = len;
      r.frame_index  = frame_no;
      r.end_of_frame = 1'b0;
      r.last         = 1'b1;
      runs_due.push_back(r);
      position       = start[15:0] + 16'(len);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
    end
  endtask

  // Monitor and scoreboard: everything sampled at the rising edge.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d runs still due", $time, runs_due.size());
      $display("TEST FAILED");
      $finish;
    end
    in_taken = in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (runs_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected run, expected none, actual count %0d frame %0d",
                   $time, out_run_count, out_frame_index);
        end else begin
          want = runs_due.pop_front();
          check_field("run_count", 16'(want.run_count), 16'(out_run_count));
          check_field("lit", 16'(want.lit), 16'(out_lit));
          check_field("frame_index", want.frame_index, out_frame_index);
          check_field("end_of_frame", 16'(want.end_of_frame), 16'(out_end_of_frame));
          check_field("last", 16'(want.last), 16'(out_last));
        end
      end
      if (cfg_write_en) frame_size = cfg_write_data;
      if (in_taken) decode_char(in_char_code);
    end
  end

  // Driver: new values at the falling edge. A character once offered is held
  // until a transaction takes it; whether to offer at all never looks at stall.
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (pending_chars.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_valid     <= 1'b1;
        in_char_code <= pending_chars.pop_front();
      end else begin
        in_valid     <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? CH_0 + 8'(n) : CH_A + 8'(n - 4'd10);
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(2))
      0: return CH_SPACE;
      1: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // Mostly well-formed hex byte pairs; some stray whitespace and raw noise,
  // which also knocks the digit pairing out of step now and then.
  task automatic queue_random_text(input int unsigned target);
    int unsigned counted;
    int unsigned sel;
    logic [7:0]  code;
    counted = 0;
    while (counted < target) begin
      sel = $urandom_range(99);
      if (sel < 5) begin
        pending_chars.push_back(pick_blank());
      end else if (sel < 10) begin
        pending_chars.push_back(8'($urandom_range(255)));
        counted++;
      end else begin
        code[7] = 1'($urandom_range(1));
        case ($urandom_range(3))
          0: code[6:0] = 7'($urandom_range(127, 110));
          1: code[6:0] = 7'($urandom_range(3));
          default: code[6:0] = 7'($urandom_range(127));
        endcase
        pending_chars.push_back(hex_char(code[7:4]));
        if ($urandom_range(9) == 0) pending_chars.push_back(pick_blank());
        pending_chars.push_back(hex_char(code[3:0]));
        counted += 2;
      end
    end
  endtask

  // Idle = nothing left to send and no run owed, plus a margin for a held
  // nibble or a split remainder still in flight.
  task automatic wait_drained();
    while (pending_chars.size() != 0 || in_valid || runs_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame_size(input logic [15:0] size);
    @(negedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= size;
    @(negedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] size, input int unsigned idle_pct,
                           input int unsigned stall_pct, input int unsigned chars);
    write_frame_size(size);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    queue_random_text(chars);
    wait_drained();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_char_code   = 8'd0;
    out_stall      = 1'b0;
    cfg_write_en   = 1'b0;
    cfg_write_data = 16'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset frame size first, then the frame edge cases at 128
    foreach (opening_text[i]) pending_chars.push_back(opening_text[i]);
    wait_drained();
    write_frame_size(16'd128);
    foreach (frame_edge_text[i]) pending_chars.push_back(frame_edge_text[i]);
    wait_drained();

    // random phases across frame sizes and flow control
    run_phase(16'd128, 0, 0, 300);
    run_phase(16'd65535, 71, 0, 260);
    // position is now far past 200: first run closes with zero pixels
    run_phase(16'd200, 0, 71, 300);
    run_phase(16'd2000, 14, 14, 300);
    run_phase(16'($urandom_range(3000, 128)), 71, 71, 200);
    run_phase(16'd129, 0, 0, 200);
    // tiny frame: remainder can exceed the frame, still split only once
    run_phase(16'd16, 14, 14, 80);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
